FILE: hw/rtl/dbc_pkg.sv
// Shared types, codes and sizes for the deltoid bucket counter bank.
// Used by every module of the block; depends on nothing.
package dbc_pkg;

   localparam int DEF_BUCKETS   = 4096;
   localparam int DEF_ITEM_BITS = 32;
   localparam int CNT_W         = 64;
   localparam int THR_W         = 63;
   localparam int MODE_W        = 2;
   localparam int BUCKET_W      = 12;
   localparam int ITEM_W        = 32;
   localparam int CHANGE_W      = 32;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1000);

   localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DECODE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic [BUCKET_W-1:0]        bucket_index;
      logic [ITEM_W-1:0]          item;
      logic signed [CHANGE_W-1:0] change;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [ITEM_W-1:0] found_item;
   } rsp_type;

   typedef struct packed {
      logic [THR_W-1:0] value;
      logic [THR_W-1:0] minus_one;
      logic             zero;
   } thr_type;

   typedef struct packed {
      logic capture_total;
      logic decode;
      logic add_delta;
   } alu_ctl_type;

   typedef struct packed {
      logic heavy_rd;
      logic heavy_sum;
   } alu_flags_type;

endpackage

FILE: hw/rtl/dbc_counter_ram.sv
// Counter memory of the bucket bank: one write and one registered read port.
// Depends on dbc_pkg for the counter width.
module dbc_counter_ram #(
   parameter int DEPTH  = dbc_pkg::DEF_BUCKETS * (dbc_pkg::DEF_ITEM_BITS + 1),
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [dbc_pkg::CNT_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [dbc_pkg::CNT_W-1:0] rd_data
);
   import dbc_pkg::*;

   logic [CNT_W-1:0] mem [DEPTH];
   logic [CNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/dbc_slot_alu.sv
// Shared 64-bit adder and heavy-counter compare used once per counter slot.
// Depends on dbc_pkg for control, flag and threshold types.
module dbc_slot_alu (
   input  logic                          clock,
   input  dbc_pkg::alu_ctl_type          ctl,
   input  dbc_pkg::thr_type              thr,
   input  logic [dbc_pkg::CNT_W-1:0]     rd_data,
   input  logic [dbc_pkg::CNT_W-1:0]     delta,
   output logic [dbc_pkg::CNT_W-1:0]     sum,
   output dbc_pkg::alu_flags_type        flags
);
   import dbc_pkg::*;

   logic [CNT_W-1:0] total_ff;
   logic [CNT_W-1:0] total_in;
   logic [CNT_W-1:0] op_a;
   logic [CNT_W-1:0] op_b;

   function automatic logic is_heavy(logic [CNT_W-1:0] x, thr_type t);
      logic [THR_W-1:0] inv;
      inv = ~x[THR_W-1:0];
      if (x[CNT_W-1]) begin
         return t.zero || (inv >= t.minus_one);
      end
      return x[THR_W-1:0] >= t.value;
   endfunction

   always_comb begin
      if (ctl.decode) begin
         op_a = total_ff;
         op_b = ~rd_data;
      end else begin
         op_a = rd_data;
         op_b = ctl.add_delta ? delta : '0;
      end
      sum = op_a + op_b + CNT_W'(ctl.decode);
      flags.heavy_rd  = is_heavy(rd_data, thr);
      flags.heavy_sum = is_heavy(sum, thr);
      total_in = ctl.capture_total ? rd_data : total_ff;
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

endmodule

FILE: hw/rtl/dbc_ctrl.sv
// Sequencer of the bucket bank: request intake, slot walk, clear sweep, decode flags.
// Depends on dbc_pkg; drives dbc_counter_ram and dbc_slot_alu.
module dbc_ctrl #(
   parameter int BUCKETS   = dbc_pkg::DEF_BUCKETS,
   parameter int ITEM_BITS = dbc_pkg::DEF_ITEM_BITS,
   parameter int ADDR_W    = ((BUCKETS * (ITEM_BITS + 1)) > 1) ?
                             $clog2(BUCKETS * (ITEM_BITS + 1)) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  dbc_pkg::req_type          req_data,
   input  logic                      rsp_free,
   output logic                      res_load,
   output dbc_pkg::rsp_type          res_data,
   output logic                      wr_en,
   output logic [ADDR_W-1:0]         wr_addr,
   output logic [dbc_pkg::CNT_W-1:0] wr_data,
   output logic                      rd_en,
   output logic [ADDR_W-1:0]         rd_addr,
   output dbc_pkg::alu_ctl_type      alu_ctl,
   output logic [dbc_pkg::CNT_W-1:0] delta,
   input  logic [dbc_pkg::CNT_W-1:0] alu_sum,
   input  dbc_pkg::alu_flags_type    alu_flags
);
   import dbc_pkg::*;

   localparam int SLOTS   = ITEM_BITS + 1;
   localparam int ENTRIES = BUCKETS * SLOTS;
   localparam int CNT_SW  = $clog2(SLOTS + 1);

   state_type              state_ff, state_in;
   logic [CNT_SW-1:0]      cnt_ff, cnt_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [ADDR_W-1:0]      wr_addr_ff;
   logic [ITEM_BITS-1:0]   item_ff, item_in;
   logic [ITEM_BITS-1:0]   res_ff, res_in;
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [CNT_W-1:0]       delta_ff, delta_in;
   logic                   dec_ok_ff, dec_ok_in;
   logic                   clr_req_ff, clr_req_in;

   logic                   accept;
   logic                   in_range;
   logic                   exec;
   logic                   exec_first;
   logic                   one;

   assign accept     = req_valid && !req_stall;
   assign in_range   = 32'(req_data.bucket_index) < BUCKETS;
   assign exec       = (state_ff == ST_RUN) && (cnt_ff != '0);
   assign exec_first = cnt_ff == CNT_SW'(1);
   assign one        = alu_flags.heavy_rd;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.mode == MODE_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if ((req_data.mode == MODE_UPDATE || req_data.mode == MODE_DECODE)
                            && in_range) begin
                  state_in = ST_RUN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CLEAR: begin
            if (addr_ff == ADDR_W'(ENTRIES - 1)) begin
               state_in = clr_req_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_RUN: begin
            if (cnt_ff == CNT_SW'(SLOTS)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = state_ff != ST_IDLE;
      res_load  = (state_ff == ST_DONE) && rsp_free;
      rd_en     = (state_ff == ST_RUN) && (cnt_ff != CNT_SW'(SLOTS));
      rd_addr   = addr_ff;
      wr_en     = 1'b0;
      wr_addr   = wr_addr_ff;
      wr_data   = alu_sum;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            wr_data = '0;
         end
         ST_RUN: begin
            wr_en = exec && (mode_ff == MODE_UPDATE);
         end
         default: wr_en = 1'b0;
      endcase
      alu_ctl.capture_total = exec && exec_first;
      alu_ctl.decode        = mode_ff == MODE_DECODE;
      alu_ctl.add_delta     = exec_first || item_ff[0];
      delta                 = delta_ff;
      res_data.found        = dec_ok_ff && (res_ff != '0);
      res_data.found_item   = dec_ok_ff ? ITEM_W'(res_ff) : '0;
   end

   always_comb begin
      cnt_in     = cnt_ff;
      addr_in    = addr_ff;
      item_in    = item_ff;
      res_in     = res_ff;
      mode_in    = mode_ff;
      delta_in   = delta_ff;
      dec_ok_in  = dec_ok_ff;
      clr_req_in = clr_req_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in     = '0;
               addr_in    = (req_data.mode == MODE_CLEAR) ? '0 :
                            ADDR_W'(32'(req_data.bucket_index) * 32'(SLOTS));
               item_in    = req_data.item[ITEM_BITS-1:0];
               res_in     = '0;
               mode_in    = req_data.mode;
               delta_in   = {{(CNT_W-CHANGE_W){req_data.change[CHANGE_W-1]}},
                             req_data.change};
               dec_ok_in  = (req_data.mode == MODE_DECODE) && in_range;
               clr_req_in = req_data.mode == MODE_CLEAR;
            end
         end
         ST_CLEAR: begin
            addr_in = addr_ff + ADDR_W'(1);
         end
         ST_RUN: begin
            cnt_in  = cnt_ff + CNT_SW'(1);
            addr_in = addr_ff + ADDR_W'(1);
            if (exec) begin
               if (exec_first) begin
                  dec_ok_in = dec_ok_ff && one;
               end else begin
                  dec_ok_in = dec_ok_ff && (one ^ alu_flags.heavy_sum);
                  res_in    = (res_ff >> 1) | (ITEM_BITS'(one) << (ITEM_BITS - 1));
                  item_in   = item_ff >> 1;
               end
            end
         end
         default: clr_req_in = clr_req_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cnt_ff     <= '0;
         addr_ff    <= '0;
         dec_ok_ff  <= 1'b0;
         clr_req_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         addr_ff    <= addr_in;
         dec_ok_ff  <= dec_ok_in;
         clr_req_ff <= clr_req_in;
      end
      wr_addr_ff <= addr_ff;
      item_ff    <= item_in;
      res_ff     <= res_in;
      mode_ff    <= mode_in;
      delta_ff   <= delta_in;
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   a_write_only_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_RUN || state_ff == ST_CLEAR))
      else $error("counter write outside slot walk or clear sweep");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> cnt_ff <= CNT_SW'(SLOTS))
      else $error("slot counter ran past the bucket");

   a_load_returns_idle: assert property (@(posedge clock) disable iff (reset)
      res_load |=> state_ff == ST_IDLE)
      else $error("result loaded but sequencer not idle");

endmodule

FILE: hw/rtl/deltoid_bucket_counter_bank.sv
// Deltoid bucket counter bank: an update or decode request walks the
// ITEM_BITS+1 counters of one bucket through a single read/write counter
// memory, one counter per cycle through one shared 64-bit adder and heavy
// compare, and no new request is accepted until its result has moved into
// the response register. A clear request sweeps the memory one counter per
// cycle; the same sweep runs after reset with req_stall high, while threshold
// writes are taken at any time.
// Depends on dbc_pkg, dbc_ctrl, dbc_slot_alu and dbc_counter_ram.
module deltoid_bucket_counter_bank #(
   parameter int BUCKETS   = dbc_pkg::DEF_BUCKETS,
   parameter int ITEM_BITS = dbc_pkg::DEF_ITEM_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  dbc_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dbc_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [dbc_pkg::THR_W-1:0] csr_wdata
);
   import dbc_pkg::*;

   localparam int ENTRIES = BUCKETS * (ITEM_BITS + 1);
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   thr_type           thr_ff, thr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              rsp_free;
   logic              res_load;
   rsp_type           res_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CNT_W-1:0]  wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CNT_W-1:0]  rd_data;
   alu_ctl_type       alu_ctl;
   logic [CNT_W-1:0]  delta;
   logic [CNT_W-1:0]  alu_sum;
   alu_flags_type     alu_flags;

   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      thr_in       = thr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (csr_valid && csr_ready) begin
         thr_in.value     = csr_wdata;
         thr_in.minus_one = csr_wdata - THR_W'(1);
         thr_in.zero      = csr_wdata == '0;
      end
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.value     <= THR_RESET;
         thr_ff.minus_one <= THR_RESET - THR_W'(1);
         thr_ff.zero      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   dbc_ctrl #(
      .BUCKETS   (BUCKETS),
      .ITEM_BITS (ITEM_BITS),
      .ADDR_W    (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_free  (rsp_free),
      .res_load  (res_load),
      .res_data  (res_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .alu_ctl   (alu_ctl),
      .delta     (delta),
      .alu_sum   (alu_sum),
      .alu_flags (alu_flags)
   );

   dbc_slot_alu u_alu (
      .clock   (clock),
      .ctl     (alu_ctl),
      .thr     (thr_ff),
      .rd_data (rd_data),
      .delta   (delta),
      .sum     (alu_sum),
      .flags   (alu_flags)
   );

   dbc_counter_ram #(
      .DEPTH  (ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

FILE: test/dbc_bank_checker.sv
// Checker for the deltoid bucket counter bank: watches the request, response and
// threshold channels, predicts each answer from its own copy of the counter bank.
// Depends on dbc_pkg for the payload types and sizes.
module dbc_bank_checker #(
   parameter int BUCKETS   = dbc_pkg::DEF_BUCKETS,
   parameter int ITEM_BITS = dbc_pkg::DEF_ITEM_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  dbc_pkg::req_type          req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  dbc_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [dbc_pkg::THR_W-1:0] csr_wdata,
   output int                        outstanding,
   output int                        fail_count
);
   import dbc_pkg::*;

   localparam int SLOTS = ITEM_BITS + 1;

   logic [CNT_W-1:0] bank [int];
   logic [THR_W-1:0] threshold;
   rsp_type          pending_answers [$];
   int               mismatches;

   function automatic logic [CNT_W-1:0] counter_at(input int addr);
      return bank.exists(addr) ? bank[addr] : '0;
   endfunction

   function automatic bit is_heavy(input logic [CNT_W-1:0] x);
      logic [CNT_W-1:0] mag;
      mag = x[CNT_W-1] ? (~x + 1'b1) : x;
      return mag >= {1'b0, threshold};
   endfunction

   function automatic rsp_type bank_answer(input req_type r);
      rsp_type          ans;
      logic [CNT_W-1:0] delta;
      logic [CNT_W-1:0] total;
      logic [CNT_W-1:0] side;
      logic [CNT_W-1:0] decoded;
      int               base;
      bit               ok;
      bit               one;
      bit               zero;
      ans = '0;
      delta = {{(CNT_W-CHANGE_W){r.change[CHANGE_W-1]}}, r.change};
      base = int'(r.bucket_index) * SLOTS;
      if (r.mode == MODE_CLEAR) begin
         bank.delete();
      end else if ((r.mode == MODE_UPDATE || r.mode == MODE_DECODE) &&
                   int'(r.bucket_index) < BUCKETS) begin
         if (r.mode == MODE_UPDATE) begin
            bank[base] = counter_at(base) + delta;
            for (int b = 0; b < ITEM_BITS; b++) begin
               if (r.item[b]) bank[base+1+b] = counter_at(base + 1 + b) + delta;
            end
         end else begin
            total = counter_at(base);
            decoded = '0;
            ok = is_heavy(total);
            for (int b = 0; b < ITEM_BITS; b++) begin
               if (ok) begin
                  side = counter_at(base + 1 + b);
                  one = is_heavy(side);
                  zero = is_heavy(total - side);
                  if (one == zero) ok = 1'b0;
                  else if (one) decoded[b] = 1'b1;
               end
            end
            if (ok) ans.found_item = decoded[ITEM_W-1:0];
            ans.found = (ans.found_item != '0);
         end
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pending_answers.delete();
         bank.delete();
         threshold = THR_RESET;
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response expected none, got found=%0d item=%h",
                        $time, rsp_data.found, rsp_data.found_item);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.found !== want.found) begin
                  mismatches++;
                  $display("%0t: found mismatch expected %0d, got %0d",
                           $time, want.found, rsp_data.found);
               end
               if (rsp_data.found_item !== want.found_item) begin
                  mismatches++;
                  $display("%0t: found_item mismatch expected %h, got %h",
                           $time, want.found_item, rsp_data.found_item);
               end
            end
         end
         if (req_valid && !req_stall) pending_answers.push_back(bank_answer(req_data));
         if (csr_valid && csr_ready) threshold = csr_wdata;
      end
      outstanding <= pending_answers.size();
      fail_count <= mismatches;
   end

endmodule

FILE: test/testbench.sv
// Top of the deltoid bucket counter bank test: clock, reset, request and threshold
// stimulus, response back-pressure and the verdict. Depends on dbc_pkg, the block
// and dbc_bank_checker.
module testbench;
   import dbc_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES = 7;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [THR_W-1:0] csr_wdata;
   int               outstanding;
   int               fail_count;

   logic [THR_W-1:0] cur_thr;
   int               gap_max;
   int               sent;
   int               clears_left;

   deltoid_bucket_counter_bank u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   dbc_bank_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("deltoid_bucket_counter_bank verification failed");
      $finish;
   end

   // response side: random stall per response, quiet stretches, two long hold-offs
   initial begin
      int taken;
      int hold_left;
      taken = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            taken++;
            if (taken == 100 || taken == 500) hold_left = 400;
            else if ((taken / 150) % 2 == 1) hold_left = 0;
            else hold_left = $urandom_range(0, 18);
         end else if (rsp_valid && hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left > 0);
      end
   end

   task automatic issue(input logic [MODE_W-1:0] m, input logic [BUCKET_W-1:0] b,
                        input logic [ITEM_W-1:0] it, input logic [CHANGE_W-1:0] ch);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{m, b, it, ch};
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_thr = v;
   endtask

   function automatic logic [CHANGE_W-1:0] pick_change(input bit neg);
      logic [CHANGE_W-1:0] mag;
      case ($urandom_range(0, 3))
         0: mag = $urandom_range(0, 32'h4000_0000);
         1: mag = (cur_thr <= 63'h4000_0000) ? CHANGE_W'(cur_thr)
                                             : $urandom_range(0, 32'h4000_0000);
         2: mag = (cur_thr != '0 && cur_thr <= 63'h4000_0000) ? CHANGE_W'(cur_thr - 1'b1)
                                                             : $urandom_range(0, 3000);
         default: mag = $urandom_range(0, 3000);
      endcase
      return neg ? -mag : mag;
   endfunction

   task automatic random_phase(input int quota);
      logic [BUCKET_W-1:0] pool [8];
      logic [BUCKET_W-1:0] bkt;
      logic [ITEM_W-1:0]   itm;
      int                  stop;
      int                  kind;
      bit                  neg;
      stop = sent + quota;
      foreach (pool[i]) pool[i] = BUCKET_W'($urandom);
      pool[0] = '0;
      pool[7] = '1;
      while (sent < stop) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            // load one item into a mostly fresh bucket, decode, sometimes take it back
            bkt = BUCKET_W'($urandom);
            case ($urandom_range(0, 3))
               0: itm = '1;
               1: itm = ITEM_W'(1) << $urandom_range(0, ITEM_W - 1);
               default: itm = $urandom;
            endcase
            neg = 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 3)) issue(MODE_UPDATE, bkt, itm, pick_change(neg));
            issue(MODE_DECODE, bkt, $urandom, $urandom);
            if ($urandom_range(0, 3) == 0) begin
               issue(MODE_UPDATE, bkt, itm, pick_change(!neg));
               issue(MODE_DECODE, bkt, $urandom, $urandom);
            end
         end else if (kind <= 7) begin
            issue(MODE_UPDATE, pool[$urandom_range(0, 7)], $urandom, $urandom);
            issue(MODE_DECODE, pool[$urandom_range(0, 7)], $urandom, $urandom);
         end else if (kind == 8) begin
            issue($urandom_range(0, 1) ? MODE_UNUSED : MODE_DECODE, BUCKET_W'($urandom),
                  $urandom, $urandom);
         end else if (clears_left > 0 && $urandom_range(0, 39) == 0) begin
            clears_left--;
            issue(MODE_CLEAR, BUCKET_W'($urandom), $urandom, $urandom);
         end else begin
            issue(MODE_DECODE, pool[$urandom_range(0, 7)], $urandom, $urandom);
         end
      end
   endtask

   initial begin
      logic [THR_W-1:0] thr_plan [PHASES];
      int               quota_plan [PHASES];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      cur_thr = THR_RESET;
      gap_max = 18;
      sent = 0;
      clears_left = 2;
      thr_plan = '{THR_W'(1), THR_W'(0), {THR_W{1'b1}}, THR_W'(5000),
                   THR_W'($urandom_range(1, 1 << 20)), THR_W'({$urandom, $urandom}),
                   THR_W'(1)};
      quota_plan = '{200, 60, 60, 150, 150, 40, 140};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset threshold
      issue(MODE_UPDATE, '0, '1, 32'sh7FFF_FFFF);
      issue(MODE_DECODE, '0, '0, '0);
      issue(MODE_UPDATE, '1, 32'h0000_0001, 32'sh8000_0000);
      issue(MODE_DECODE, '1, '1, '1);
      issue(MODE_UPDATE, 12'd5, '0, 32'sd5000);
      issue(MODE_DECODE, 12'd5, '0, '0);
      issue(MODE_UPDATE, 12'd7, 32'hA5A5_5A5A, 32'sd999);
      issue(MODE_DECODE, 12'd7, '0, '0);
      issue(MODE_UPDATE, 12'd7, 32'hA5A5_5A5A, 32'sd1);
      issue(MODE_DECODE, 12'd7, '0, '0);
      issue(MODE_UPDATE, 12'd9, 32'h0000_1234, 32'sd3000);
      issue(MODE_UPDATE, 12'd9, 32'h0000_00FF, 32'sd3000);
      issue(MODE_DECODE, 12'd9, '0, '0);
      issue(MODE_UPDATE, 12'd9, 32'h0000_00FF, -32'sd3000);
      issue(MODE_DECODE, 12'd9, '0, '0);
      issue(MODE_UNUSED, '0, '1, '1);
      issue(MODE_DECODE, '0, '0, '0);
      issue(MODE_CLEAR, 12'd9, '0, '0);
      issue(MODE_DECODE, '0, '0, '0);
      issue(MODE_DECODE, 12'd9, '0, '0);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_threshold(thr_plan[p]);
         gap_max = (p % 2 == 0) ? 18 : 0;
         random_phase(quota_plan[p]);
      end
      settle();
      if (fail_count == 0) begin
         $display("deltoid_bucket_counter_bank verification clean");
      end else begin
         $display("deltoid_bucket_counter_bank verification failed");
      end
      $finish;
   end

endmodule

FILE: deltoid_bucket_counter_bank.f
hw/rtl/dbc_pkg.sv
hw/rtl/dbc_counter_ram.sv
hw/rtl/dbc_slot_alu.sv
hw/rtl/dbc_ctrl.sv
hw/rtl/deltoid_bucket_counter_bank.sv
test/dbc_bank_checker.sv
test/testbench.sv
